>>> rtl/core/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation unit.
// Holds the microcode control word layout, calibration register layout and flags.
// No dependencies.
package bpc_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Calibration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_SENS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFF = 3'd5;

  localparam int unsigned RAW_W   = 24;
  localparam int unsigned HALF_W  = 12;
  localparam int unsigned DT_W    = 25;
  localparam int unsigned TEMP_W  = 15;
  localparam int unsigned PRES_W  = 17;
  localparam int unsigned ALU_W   = 64;
  localparam int unsigned OS_W    = 50;
  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned SHAMT_W = 5;
  localparam int unsigned PC_W    = 5;

  localparam logic [PC_W-1:0] LAST_STEP = 5'd23;

  localparam int signed TEMP_REF = 2000;
  localparam int signed TEMP_LOW = -1500;
  localparam int signed TEMP_MIN = -4000;
  localparam int signed TEMP_MAX = 8500;

  typedef struct packed {
    logic [CFG_W-1:0] pres_sens;
    logic [CFG_W-1:0] pres_off;
    logic [CFG_W-1:0] sens_tc;
    logic [CFG_W-1:0] off_tc;
    logic [CFG_W-1:0] ref_temp;
    logic [CFG_W-1:0] temp_coeff;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    MA_DT,
    MA_SENS,
    MA_D,
    MA_E
  } mul_a_sel_e;

  typedef enum logic [3:0] {
    MB_C6,
    MB_C4,
    MB_C3,
    MB_DT_LO,
    MB_DT_HI,
    MB_D5,
    MB_E7,
    MB_E11,
    MB_RAW_LO,
    MB_RAW_HI
  } mul_b_sel_e;

  typedef enum logic [2:0] {
    X_ZERO,
    X_ACC,
    X_OFF,
    X_SENS,
    X_C2S16,
    X_C1S15,
    X_TREF
  } alu_x_e;

  typedef enum logic [2:0] {
    Y_PROD,
    Y_PROD12,
    Y_ACC,
    Y_SENS,
    Y_OFF
  } alu_y_e;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_ACC,
    DST_OFF,
    DST_SENS
  } alu_dst_e;

  typedef enum logic [2:0] {
    J_NONE,
    J_PRESSURE,
    J_ACC_GE_REF,
    J_TEMP_GE_REF,
    J_TEMP_GE_LOW
  } jump_e;

  typedef struct packed {
    mul_a_sel_e         mul_a;
    mul_b_sel_e         mul_b;
    alu_x_e             alu_x;
    alu_y_e             alu_y;
    logic               alu_sub;
    logic [SHAMT_W-1:0] alu_shift;
    alu_dst_e           dst;
    logic               dt_wr;
    logic               temp_wr;
    logic               pres_wr;
    jump_e              jmp;
    logic [PC_W-1:0]    target;
    logic               done;
  } ctrl_word_t;

  localparam ctrl_word_t CW_NOP = '0;

  typedef struct packed {
    logic is_pressure;
    logic acc_ge_ref;
    logic temp_ge_ref;
    logic temp_ge_low;
  } dp_flags_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

endpackage

>>> rtl/core/bpc_ucode_rom.sv
// Microprogram store: one control word per step for temperature and pressure items.
// Depends on bpc_pkg.
module bpc_ucode_rom (
  input  logic [bpc_pkg::PC_W-1:0] pc_i,
  output bpc_pkg::ctrl_word_t      cw_o
);
  import bpc_pkg::*;

  localparam logic [PC_W-1:0] STEP_T_STORE = 5'd7;
  localparam logic [PC_W-1:0] STEP_P_ENTRY = 5'd9;
  localparam logic [PC_W-1:0] STEP_P_FINAL = 5'd16;

  localparam logic [SHAMT_W-1:0] SH_TEMP = 5'd23;
  localparam logic [SHAMT_W-1:0] SH_SQ   = 5'd31;
  localparam logic [SHAMT_W-1:0] SH_OFF  = 5'd7;
  localparam logic [SHAMT_W-1:0] SH_SENS = 5'd8;
  localparam logic [SHAMT_W-1:0] SH_MUL  = 5'd21;
  localparam logic [SHAMT_W-1:0] SH_OUT  = 5'd15;
  localparam logic [SHAMT_W-1:0] SH_HALF = 5'd1;
  localparam logic [SHAMT_W-1:0] SH_QTR  = 5'd2;

  always_comb begin
    cw_o = CW_NOP;
    case (pc_i)
      // temperature item
      5'd0: begin
        cw_o.jmp    = J_PRESSURE;
        cw_o.target = STEP_P_ENTRY;
      end
      5'd1: begin
        cw_o.dt_wr = 1'b1;
      end
      5'd2: begin
        cw_o.mul_a = MA_DT;
        cw_o.mul_b = MB_C6;
      end
      5'd3: begin
        cw_o.alu_x     = X_TREF;
        cw_o.alu_y     = Y_PROD;
        cw_o.alu_shift = SH_TEMP;
        cw_o.dst       = DST_ACC;
        cw_o.mul_a     = MA_DT;
        cw_o.mul_b     = MB_DT_LO;
      end
      5'd4: begin
        // sens holds dT squared as scratch on this path
        cw_o.alu_x = X_ZERO;
        cw_o.alu_y = Y_PROD;
        cw_o.dst   = DST_SENS;
        cw_o.mul_a = MA_DT;
        cw_o.mul_b = MB_DT_HI;
      end
      5'd5: begin
        cw_o.alu_x  = X_SENS;
        cw_o.alu_y  = Y_PROD12;
        cw_o.dst    = DST_SENS;
        cw_o.jmp    = J_ACC_GE_REF;
        cw_o.target = STEP_T_STORE;
      end
      5'd6: begin
        cw_o.alu_x     = X_ACC;
        cw_o.alu_y     = Y_SENS;
        cw_o.alu_sub   = 1'b1;
        cw_o.alu_shift = SH_SQ;
        cw_o.dst       = DST_ACC;
      end
      5'd7: begin
        cw_o.temp_wr = 1'b1;
      end
      5'd8: begin
        cw_o.done = 1'b1;
      end
      // pressure item
      5'd9: begin
        cw_o.mul_a = MA_DT;
        cw_o.mul_b = MB_C4;
      end
      5'd10: begin
        cw_o.alu_x     = X_C2S16;
        cw_o.alu_y     = Y_PROD;
        cw_o.alu_shift = SH_OFF;
        cw_o.dst       = DST_OFF;
        cw_o.mul_a     = MA_DT;
        cw_o.mul_b     = MB_C3;
      end
      5'd11: begin
        cw_o.alu_x     = X_C1S15;
        cw_o.alu_y     = Y_PROD;
        cw_o.alu_shift = SH_SENS;
        cw_o.dst       = DST_SENS;
        cw_o.mul_a     = MA_D;
        cw_o.mul_b     = MB_D5;
        cw_o.jmp       = J_TEMP_GE_REF;
        cw_o.target    = STEP_P_FINAL;
      end
      5'd12: begin
        // hold 5*d*d in the product register for the next step
        cw_o.alu_x     = X_OFF;
        cw_o.alu_y     = Y_PROD;
        cw_o.alu_sub   = 1'b1;
        cw_o.alu_shift = SH_HALF;
        cw_o.dst       = DST_OFF;
        cw_o.mul_a     = MA_D;
        cw_o.mul_b     = MB_D5;
      end
      5'd13: begin
        cw_o.alu_x     = X_SENS;
        cw_o.alu_y     = Y_PROD;
        cw_o.alu_sub   = 1'b1;
        cw_o.alu_shift = SH_QTR;
        cw_o.dst       = DST_SENS;
        cw_o.mul_a     = MA_E;
        cw_o.mul_b     = MB_E7;
        cw_o.jmp       = J_TEMP_GE_LOW;
        cw_o.target    = STEP_P_FINAL;
      end
      5'd14: begin
        cw_o.alu_x   = X_OFF;
        cw_o.alu_y   = Y_PROD;
        cw_o.alu_sub = 1'b1;
        cw_o.dst     = DST_OFF;
        cw_o.mul_a   = MA_E;
        cw_o.mul_b   = MB_E11;
      end
      5'd15: begin
        cw_o.alu_x     = X_SENS;
        cw_o.alu_y     = Y_PROD;
        cw_o.alu_sub   = 1'b1;
        cw_o.alu_shift = SH_HALF;
        cw_o.dst       = DST_SENS;
      end
      5'd16: begin
        cw_o.mul_a = MA_SENS;
        cw_o.mul_b = MB_RAW_LO;
      end
      5'd17: begin
        cw_o.alu_x = X_ZERO;
        cw_o.alu_y = Y_PROD;
        cw_o.dst   = DST_ACC;
        cw_o.mul_a = MA_SENS;
        cw_o.mul_b = MB_RAW_HI;
      end
      5'd18: begin
        cw_o.alu_x = X_ACC;
        cw_o.alu_y = Y_PROD12;
        cw_o.dst   = DST_ACC;
      end
      5'd19: begin
        cw_o.alu_x     = X_ZERO;
        cw_o.alu_y     = Y_ACC;
        cw_o.alu_shift = SH_MUL;
        cw_o.dst       = DST_ACC;
      end
      5'd20: begin
        cw_o.alu_x   = X_ACC;
        cw_o.alu_y   = Y_OFF;
        cw_o.alu_sub = 1'b1;
        cw_o.dst     = DST_ACC;
      end
      5'd21: begin
        cw_o.alu_x     = X_ZERO;
        cw_o.alu_y     = Y_ACC;
        cw_o.alu_shift = SH_OUT;
        cw_o.dst       = DST_ACC;
      end
      5'd22: begin
        cw_o.pres_wr = 1'b1;
      end
      5'd23: begin
        cw_o.done = 1'b1;
      end
      default: begin
        cw_o.done = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/core/bpc_sequencer.sv
// Step counter, conditional jumps and input handshake for the compensation microprogram.
// Depends on bpc_pkg.
module bpc_sequencer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     out_free_i,
  input  bpc_pkg::ctrl_word_t      cw_i,
  input  bpc_pkg::dp_flags_t       flags_i,
  output logic [bpc_pkg::PC_W-1:0] pc_o,
  output logic                     load_o,
  output logic                     step_en_o,
  output logic                     finish_o
);
  import bpc_pkg::*;

  seq_state_e      state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    case (cw_i.jmp)
      J_NONE:        taken = 1'b0;
      J_PRESSURE:    taken = flags_i.is_pressure;
      J_ACC_GE_REF:  taken = flags_i.acc_ge_ref;
      J_TEMP_GE_REF: taken = flags_i.temp_ge_ref;
      J_TEMP_GE_LOW: taken = flags_i.temp_ge_low;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    in_stall_o = 1'b1;
    load_o     = 1'b0;
    step_en_o  = 1'b0;
    finish_o   = 1'b0;
    case (state_q)
      SEQ_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          load_o  = 1'b1;
          pc_d    = '0;
          state_d = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (cw_i.done) begin
          // hold on the last step until the output register frees up
          if (out_free_i) begin
            finish_o = 1'b1;
            state_d  = SEQ_IDLE;
          end
        end else begin
          step_en_o = 1'b1;
          pc_d      = taken ? cw_i.target : pc_q + PC_W'(1);
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  assign pc_o = pc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> (state_q == SEQ_RUN) && (pc_q == '0))
    else $error("program did not start at step zero after a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN) |-> (pc_q <= LAST_STEP))
    else $error("step counter ran past the program");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN) && cw_i.done && !out_free_i |=> (state_q == SEQ_RUN) && $stable(pc_q))
    else $error("finished item dropped while the output was blocked");

endmodule

>>> rtl/core/bpc_datapath.sv
// Datapath: shared 36x18 multiplier, 64-bit add/shift unit with truncating shifts,
// scratch and state registers. Depends on bpc_pkg.
module bpc_datapath #(
  parameter int unsigned ADC_WIDTH = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic                               kind_i,
  input  logic [ADC_WIDTH-1:0]               raw_i,
  input  logic                               step_en_i,
  input  bpc_pkg::ctrl_word_t                cw_i,
  input  bpc_pkg::cfg_regs_t                 cfg_i,
  output bpc_pkg::dp_flags_t                 flags_o,
  output logic signed [bpc_pkg::TEMP_W-1:0]  temp_o,
  output logic [bpc_pkg::PRES_W-1:0]         pres_o,
  output logic                               kind_o
);
  import bpc_pkg::*;

  logic                       kind_q;
  logic [ADC_WIDTH-1:0]       raw_q;
  logic signed [DT_W-1:0]     dt_q;
  logic signed [TEMP_W-1:0]   temp_q;
  logic [PRES_W-1:0]          pres_q;
  logic signed [ALU_W-1:0]    acc_q;
  logic signed [OS_W-1:0]     off_q;
  logic signed [OS_W-1:0]     sens_q;
  logic signed [PROD_W-1:0]   prod_q;

  logic [RAW_W-1:0]           raw_full;
  logic signed [DT_W-1:0]     dt_new;
  logic signed [MUL_B_W-1:0]  temp_ext, d_val, e_val, d5, e7, e11;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_d;

  logic signed [ALU_W-1:0]    x_val, y_val, y_shr, y_add, alu_res;
  logic [ALU_W-1:0]           low_mask;
  logic                       round_up, carry_in;

  logic signed [TEMP_W-1:0]   temp_clamp;
  logic [PRES_W-1:0]          pres_clamp;

  assign raw_full = RAW_W'(raw_q);
  assign dt_new   = $signed({1'b0, raw_full}) - $signed({1'b0, cfg_i.ref_temp, 8'b0});

  // second-order terms: d = T - 20.00 C, e = T + 15.00 C, small constant multiples
  always_comb begin
    temp_ext = MUL_B_W'(temp_q);
    d_val    = temp_ext - $signed(MUL_B_W'(TEMP_REF));
    e_val    = temp_ext - $signed(MUL_B_W'(TEMP_LOW));
    d5       = (d_val <<< 2) + d_val;
    e7       = (e_val <<< 3) - e_val;
    e11      = (e_val <<< 3) + (e_val <<< 1) + e_val;
  end

  always_comb begin
    case (cw_i.mul_a)
      MA_DT:   mul_a = MUL_A_W'(dt_q);
      MA_SENS: mul_a = $signed(sens_q[MUL_A_W-1:0]);
      MA_D:    mul_a = MUL_A_W'(d_val);
      MA_E:    mul_a = MUL_A_W'(e_val);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (cw_i.mul_b)
      MB_C6:     mul_b = $signed(MUL_B_W'(cfg_i.temp_coeff));
      MB_C4:     mul_b = $signed(MUL_B_W'(cfg_i.off_tc));
      MB_C3:     mul_b = $signed(MUL_B_W'(cfg_i.sens_tc));
      MB_DT_LO:  mul_b = $signed(MUL_B_W'(dt_q[HALF_W-1:0]));
      MB_DT_HI:  mul_b = MUL_B_W'($signed(dt_q[DT_W-1:HALF_W]));
      MB_D5:     mul_b = d5;
      MB_E7:     mul_b = e7;
      MB_E11:    mul_b = e11;
      MB_RAW_LO: mul_b = $signed(MUL_B_W'(raw_full[HALF_W-1:0]));
      MB_RAW_HI: mul_b = $signed(MUL_B_W'(raw_full[RAW_W-1:HALF_W]));
      default:   mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    case (cw_i.alu_x)
      X_ZERO:  x_val = '0;
      X_ACC:   x_val = acc_q;
      X_OFF:   x_val = ALU_W'(off_q);
      X_SENS:  x_val = ALU_W'(sens_q);
      X_C2S16: x_val = $signed(ALU_W'({cfg_i.pres_off, 16'b0}));
      X_C1S15: x_val = $signed(ALU_W'({cfg_i.pres_sens, 15'b0}));
      X_TREF:  x_val = $signed(ALU_W'(TEMP_REF));
      default: x_val = '0;
    endcase
  end

  always_comb begin
    case (cw_i.alu_y)
      Y_PROD:   y_val = ALU_W'(prod_q);
      Y_PROD12: y_val = ALU_W'(prod_q) <<< HALF_W;
      Y_ACC:    y_val = acc_q;
      Y_SENS:   y_val = ALU_W'(sens_q);
      Y_OFF:    y_val = ALU_W'(off_q);
      default:  y_val = '0;
    endcase
  end

  // truncating shift: round a negative operand toward zero through the carry-in
  always_comb begin
    y_shr    = y_val >>> cw_i.alu_shift;
    low_mask = (ALU_W'(1) << cw_i.alu_shift) - ALU_W'(1);
    round_up = y_val[ALU_W-1] && ((y_val & low_mask) != '0);
    y_add    = cw_i.alu_sub ? ~y_shr : y_shr;
    carry_in = cw_i.alu_sub ? ~round_up : round_up;
    alu_res  = x_val + y_add + ALU_W'(carry_in);
  end

  always_comb begin
    if (acc_q < $signed(ALU_W'(TEMP_MIN))) begin
      temp_clamp = $signed(TEMP_W'(TEMP_MIN));
    end else if (acc_q > $signed(ALU_W'(TEMP_MAX))) begin
      temp_clamp = $signed(TEMP_W'(TEMP_MAX));
    end else begin
      temp_clamp = acc_q[TEMP_W-1:0];
    end
    if (acc_q[ALU_W-1]) begin
      pres_clamp = '0;
    end else if (acc_q[ALU_W-2:PRES_W] != '0) begin
      pres_clamp = '1;
    end else begin
      pres_clamp = acc_q[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= '0;
      temp_q <= '0;
      pres_q <= '0;
    end else if (step_en_i) begin
      if (cw_i.dt_wr) begin
        dt_q <= dt_new;
      end
      if (cw_i.temp_wr) begin
        temp_q <= temp_clamp;
      end
      if (cw_i.pres_wr) begin
        pres_q <= pres_clamp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= kind_i;
      raw_q  <= raw_i;
    end
    if (step_en_i) begin
      prod_q <= prod_d;
      case (cw_i.dst)
        DST_NONE: ;
        DST_ACC:  acc_q  <= alu_res;
        DST_OFF:  off_q  <= alu_res[OS_W-1:0];
        DST_SENS: sens_q <= alu_res[OS_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    flags_o.is_pressure = kind_q;
    flags_o.acc_ge_ref  = acc_q >= $signed(ALU_W'(TEMP_REF));
    flags_o.temp_ge_ref = temp_q >= $signed(TEMP_W'(TEMP_REF));
    flags_o.temp_ge_low = temp_q >= $signed(TEMP_W'(TEMP_LOW));
  end

  assign temp_o = temp_q;
  assign pres_o = pres_q;
  assign kind_o = kind_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (temp_q >= $signed(TEMP_W'(TEMP_MIN))) && (temp_q <= $signed(TEMP_W'(TEMP_MAX))))
    else $error("stored temperature outside its saturation range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && (cw_i.mul_a == MA_SENS) |->
      (sens_q[OS_W-1:MUL_A_W-1] == '0) || (sens_q[OS_W-1:MUL_A_W-1] == '1))
    else $error("sensitivity does not fit the multiplier operand");

endmodule

>>> rtl/core/barometric_pressure_compensation_unit.sv
// Top level of the barometric pressure compensation unit: calibration registers,
// output register, microcode sequencer, program store and datapath. Uses bpc_pkg.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   kind_i, raw_reading_i
//   out      output     out_valid_o / out_stall_i temperature_out_o, pressure_out_o,
//                                                 pressure_updated_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A temperature transaction runs 8 microprogram steps (9 below 20.00 C), a pressure
// transaction 12 (14 below 20.00 C, 16 below -15.00 C); the result is valid on the
// cycle after the last step, and the next input can be accepted in that same cycle.
// Every product goes through the one 36x18 multiplier, so the program length sets
// the rate. Reset clears calibration words, dT, temperature and pressure.
// A full output register holds the sequencer on its last step; the input stalls
// whenever a transaction is in progress.
module barometric_pressure_compensation_unit #(
  parameter int unsigned ADC_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [bpc_pkg::RAW_W-1:0]            raw_reading_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bpc_pkg::TEMP_W-1:0]    temperature_out_o,
  output logic [bpc_pkg::PRES_W-1:0]           pressure_out_o,
  output logic                                 pressure_updated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bpc_pkg::CFG_W-1:0]            cfg_data_i
);
  import bpc_pkg::*;

  cfg_regs_t                cfg_q;
  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic [PRES_W-1:0]        out_pres_q;
  logic                     out_upd_q;

  logic                     out_free;
  logic [PC_W-1:0]          pc;
  ctrl_word_t               cw;
  dp_flags_t                flags;
  logic                     load, step_en, finish;
  logic signed [TEMP_W-1:0] temp_cur;
  logic [PRES_W-1:0]        pres_cur;
  logic                     kind_cur;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PRES_SENS:  cfg_q.pres_sens  <= cfg_data_i;
        CFG_PRES_OFF:   cfg_q.pres_off   <= cfg_data_i;
        CFG_SENS_TC:    cfg_q.sens_tc    <= cfg_data_i;
        CFG_OFF_TC:     cfg_q.off_tc     <= cfg_data_i;
        CFG_REF_TEMP:   cfg_q.ref_temp   <= cfg_data_i;
        CFG_TEMP_COEFF: cfg_q.temp_coeff <= cfg_data_i;
        default:        ; // drop writes beyond the last register
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_temp_q <= temp_cur;
      out_pres_q <= pres_cur;
      out_upd_q  <= kind_cur;
    end
  end

  bpc_ucode_rom u_rom (
    .pc_i (pc),
    .cw_o (cw)
  );

  bpc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .cw_i       (cw),
    .flags_i    (flags),
    .pc_o       (pc),
    .load_o     (load),
    .step_en_o  (step_en),
    .finish_o   (finish)
  );

  bpc_datapath #(
    .ADC_WIDTH (ADC_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .kind_i    (kind_i),
    .raw_i     (raw_reading_i[ADC_WIDTH-1:0]),
    .step_en_i (step_en),
    .cw_i      (cw),
    .cfg_i     (cfg_q),
    .flags_o   (flags),
    .temp_o    (temp_cur),
    .pres_o    (pres_cur),
    .kind_o    (kind_cur)
  );

  assign out_valid_o        = out_valid_q;
  assign temperature_out_o  = out_temp_q;
  assign pressure_out_o     = out_pres_q;
  assign pressure_updated_o = out_upd_q;

endmodule

>>> test/barometric_pressure_compensation_unit_test.sv
// Self-checking testbench for the barometric pressure compensation unit.
// Drives raw conversions and calibration writes, predicts each result and compares it.
// Depends on bpc_pkg and barometric_pressure_compensation_unit.
`timescale 1ns / 100ps

module barometric_pressure_compensation_unit_test;

  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_PRES = 1'b1;

  // Indexes past the last calibration word; the block drops these writes
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam longint PRES_MAX      = 131071;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     LONG_HOLD     = 150;
  localparam int     STALL_LIMIT   = 3000;
  localparam int     PHASE_ITEMS   = 255;
  localparam int     MAX_REPORTS   = 10;

  typedef struct {
    logic        kind;
    logic [23:0] raw;
  } conversion_t;

  typedef struct {
    logic signed [bpc_pkg::TEMP_W-1:0] temp;
    logic [bpc_pkg::PRES_W-1:0]        pres;
    logic                              upd;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                  in_valid = 1'b0;
  logic                                  in_kind = 1'b0;
  logic [bpc_pkg::RAW_W-1:0]             in_raw = '0;
  logic                                  out_stall = 1'b0;
  logic                                  cfg_valid = 1'b0;
  logic [bpc_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
  logic [bpc_pkg::CFG_W-1:0]             cfg_data = '0;

  logic                                  in_stall_o;
  logic                                  out_valid_o;
  logic signed [bpc_pkg::TEMP_W-1:0]     temperature_out_o;
  logic [bpc_pkg::PRES_W-1:0]            pressure_out_o;
  logic                                  pressure_updated_o;
  logic                                  cfg_ready_o;

  conversion_t pending_readings[$];
  reading_t    expected_readings[$];

  bpc_pkg::cfg_regs_t cal_copy;
  longint dt_hold;
  longint temp_hold;
  longint pres_hold;

  int send_gap_pct;
  int recv_stall_pct;
  int hold_seq;
  int mismatches;

  barometric_pressure_compensation_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .kind_i             (in_kind),
    .raw_reading_i      (in_raw),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .temperature_out_o  (temperature_out_o),
    .pressure_out_o     (pressure_out_o),
    .pressure_updated_o (pressure_updated_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint widen16(logic [15:0] v);
    return longint'({48'd0, v});
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Update the held temperature or pressure and queue the reading it produces
  function automatic void predict_reading(logic kind, logic [23:0] raw_in);
    longint raw, dt, t, off, sens, d, c, e, q, p;
    reading_t r;
    raw = longint'({40'd0, raw_in});
    if (kind == KIND_TEMP) begin
      dt = raw - longint'({40'd0, cal_copy.ref_temp, 8'd0});
      t = longint'(bpc_pkg::TEMP_REF) + (dt * widen16(cal_copy.temp_coeff)) / 64'sd8388608;
      if (t < bpc_pkg::TEMP_REF) t = t - (dt * dt) / 64'sd2147483648;
      dt_hold = dt;
      temp_hold = clamp(t, bpc_pkg::TEMP_MIN, bpc_pkg::TEMP_MAX);
    end else begin
      off = (widen16(cal_copy.pres_off) <<< 16)
          + (dt_hold * widen16(cal_copy.off_tc)) / 64'sd128;
      sens = (widen16(cal_copy.pres_sens) <<< 15)
           + (dt_hold * widen16(cal_copy.sens_tc)) / 64'sd256;
      // Cold and very cold corrections go by the stored, saturated temperature
      if (temp_hold < bpc_pkg::TEMP_REF) begin
        d = temp_hold - bpc_pkg::TEMP_REF;
        c = (64'sd5 * d * d) / 64'sd2;
        off = off - c;
        sens = sens - c / 64'sd2;
        if (temp_hold < bpc_pkg::TEMP_LOW) begin
          e = temp_hold - bpc_pkg::TEMP_LOW;
          q = e * e;
          off = off - 64'sd7 * q;
          sens = sens - (64'sd11 * q) / 64'sd2;
        end
      end
      p = ((sens * raw) / 64'sd2097152 - off) / 64'sd32768;
      pres_hold = clamp(p, 0, PRES_MAX);
    end
    r.temp = temp_hold[bpc_pkg::TEMP_W-1:0];
    r.pres = pres_hold[bpc_pkg::PRES_W-1:0];
    r.upd  = kind;
    expected_readings.push_back(r);
  endfunction

  // Driver: offer the next pending conversion, hold it until accepted
  always @(posedge clk_i) begin
    conversion_t nxt;
    logic        taken;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall_o;
      if (taken) predict_reading(in_kind, in_raw);
      if (!in_valid || taken) begin
        if (pending_readings.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = pending_readings.pop_front();
          in_valid <= 1'b1;
          in_kind  <= nxt.kind;
          in_raw   <= nxt.raw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted reading, then pick the stall for the next cycle
  int hold_left = 0;
  int seen_hold_seq = 0;
  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected reading: temp %0d pres %0d upd %0b",
                   temperature_out_o, pressure_out_o, pressure_updated_o);
      end else begin
        e = expected_readings.pop_front();
        if (temperature_out_o !== e.temp || pressure_out_o !== e.pres
            || pressure_updated_o !== e.upd) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: temp exp %0d got %0d, pres exp %0d got %0d, upd exp %0b got %0b",
                     e.temp, temperature_out_o, e.pres, pressure_out_o,
                     e.upd, pressure_updated_o);
        end
      end
    end
    if (hold_seq != seen_hold_seq) begin
      seen_hold_seq = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)
        || (cfg_valid && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("barometric_pressure_compensation_unit_test: errors");
        $finish;
      end
    end
  end

  task automatic write_cal(input logic [bpc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      bpc_pkg::CFG_PRES_SENS:  cal_copy.pres_sens  = val;
      bpc_pkg::CFG_PRES_OFF:   cal_copy.pres_off   = val;
      bpc_pkg::CFG_SENS_TC:    cal_copy.sens_tc    = val;
      bpc_pkg::CFG_OFF_TC:     cal_copy.off_tc     = val;
      bpc_pkg::CFG_REF_TEMP:   cal_copy.ref_temp   = val;
      bpc_pkg::CFG_TEMP_COEFF: cal_copy.temp_coeff = val;
      default: ;
    endcase
  endtask

  task automatic write_all_cal(input logic [15:0] c1, c2, c3, c4, c5, c6);
    write_cal(bpc_pkg::CFG_PRES_SENS, c1);
    write_cal(bpc_pkg::CFG_PRES_OFF, c2);
    write_cal(bpc_pkg::CFG_SENS_TC, c3);
    write_cal(bpc_pkg::CFG_OFF_TC, c4);
    write_cal(bpc_pkg::CFG_REF_TEMP, c5);
    write_cal(bpc_pkg::CFG_TEMP_COEFF, c6);
  endtask

  task automatic add_item(input logic kind, input logic [23:0] raw);
    conversion_t c;
    c.kind = kind;
    c.raw  = raw;
    pending_readings.push_back(c);
  endtask

  // Wait until every queued conversion has produced its reading, then let the block settle
  task automatic wait_settled();
    do @(negedge clk_i);
    while (pending_readings.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Temperature conversions cluster around the reference point to hit the cold branches
  function automatic logic [23:0] temp_raw();
    logic [23:0] centre, offs, r;
    centre = {cal_copy.ref_temp, 8'd0};
    offs = 24'($urandom);
    case ($urandom_range(4))
      0:       r = 24'($urandom);
      1:       r = centre + {{8{offs[23]}}, offs[15:0]};
      2:       r = centre + {{4{offs[23]}}, offs[19:0]};
      3:       r = centre - {4'd0, offs[19:0]};
      default: r = ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h000000;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] pres_raw();
    logic [23:0] r;
    case ($urandom_range(5))
      0:       r = 24'h000000;
      1:       r = 24'hFFFFFF;
      default: r = 24'($urandom);
    endcase
    return r;
  endfunction

  // Mostly a temperature followed by one to three pressures, the rest loose conversions
  task automatic random_phase(input int n_items);
    int added, n_pres;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(9) < 8) begin
        add_item(KIND_TEMP, temp_raw());
        n_pres = $urandom_range(3, 1);
        repeat (n_pres) add_item(KIND_PRES, pres_raw());
        added += 1 + n_pres;
      end else begin
        add_item(1'($urandom_range(1)), 24'($urandom));
        added++;
      end
    end
  endtask

  task automatic random_cal();
    write_all_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
  endtask

  initial begin
    cal_copy = '0;
    dt_hold = 0;
    temp_hold = 0;
    pres_hold = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_seq = 0;
    mismatches = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset calibration: pressure before any temperature, then range ends
    send_gap_pct = 35;
    recv_stall_pct = 85;
    add_item(KIND_PRES, 24'hFFFFFF);
    add_item(KIND_PRES, 24'h000000);
    add_item(KIND_TEMP, 24'h000000);
    add_item(KIND_TEMP, 24'hFFFFFF);
    add_item(KIND_PRES, 24'h123456);
    wait_settled();

    // Typical factory words: normal, frozen, hot and exact reference point
    write_all_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    add_item(KIND_TEMP, 24'd8077216);
    add_item(KIND_PRES, 24'd6465444);
    add_item(KIND_TEMP, 24'h000000);
    add_item(KIND_PRES, 24'hFFFFFF);
    add_item(KIND_PRES, 24'h000000);
    add_item(KIND_TEMP, 24'hFFFFFF);
    add_item(KIND_PRES, 24'hFFFFFF);
    add_item(KIND_TEMP, 24'd8566784);
    add_item(KIND_PRES, 24'd9085466);
    wait_settled();

    // All words at their maximum; spare indexes must not disturb anything
    write_all_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_cal(CFG_SPARE_LO, 16'h0000);
    write_cal(CFG_SPARE_HI, 16'h0000);
    add_item(KIND_TEMP, 24'h000000);
    add_item(KIND_PRES, 24'hFFFFFF);
    add_item(KIND_TEMP, 24'hFFFFFF);
    add_item(KIND_PRES, 24'h000000);
    add_item(KIND_PRES, 24'hFFFFFF);
    wait_settled();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        2: write_all_cal(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: random_cal();
      endcase
      if ($urandom_range(1) != 0)
        write_cal(CFG_SPARE_LO + 3'($urandom_range(1)), 16'($urandom));
      if (phase < 2) begin
        send_gap_pct = 35;
        recv_stall_pct = 85;
      end else if (phase < 4) begin
        send_gap_pct = 85;
        recv_stall_pct = 35;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      random_phase(PHASE_ITEMS);
      // Hold off the output while conversions keep arriving
      if (phase == 4) hold_seq++;
      wait_settled();
    end

    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("barometric_pressure_compensation_unit_test: clean");
    end else begin
      $display("barometric_pressure_compensation_unit_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/bpc_pkg.sv
rtl/core/bpc_ucode_rom.sv
rtl/core/bpc_sequencer.sv
rtl/core/bpc_datapath.sv
rtl/core/barometric_pressure_compensation_unit.sv
test/barometric_pressure_compensation_unit_test.sv
